// File: hdl/salt_pepper_noise_remover_defines.svh
// Assertion macros shared by the salt and pepper noise remover RTL.
`ifndef SALT_PEPPER_NOISE_REMOVER_DEFINES_SVH
`define SALT_PEPPER_NOISE_REMOVER_DEFINES_SVH

// Same-cycle implication on clk, off while rst_n is low.
`define SPN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, off while rst_n is low.
`define SPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/spn_pkg.sv
// Package: types, codes and constants of the salt and pepper noise remover.
`timescale 1ns / 1ps

package spn_pkg;

    localparam int SAMPLE_BITS    = 8;
    localparam int NEIGHBOURS     = 8;
    localparam int AVG_SHIFT      = 3;
    localparam int SUM_BITS       = SAMPLE_BITS + AVG_SHIFT;

    localparam int WIDTH_BITS     = 12;
    localparam int HEIGHT_BITS    = 16;
    localparam int MODE_BITS      = 2;
    localparam int TOL_BITS       = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam int OUT_DEPTH      = 8;
    localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS   = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NOISE_MODE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_USE_AVERAGE  = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [WIDTH_BITS-1:0]  RST_FRAME_WIDTH  = 12'd1920;
    localparam logic [HEIGHT_BITS-1:0] RST_FRAME_HEIGHT = 16'd1080;
    localparam logic [MODE_BITS-1:0]   RST_NOISE_MODE   = 2'd3;
    localparam logic [TOL_BITS-1:0]    RST_TOLERANCE    = 8'd3;
    localparam logic                   RST_USE_AVERAGE  = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic    opcode;
        sample_t sample;
    } in_item_t;

    typedef struct packed {
        sample_t out_sample;
        logic    was_replaced;
        logic    noise_kind;
        logic    frame_last;
    } out_item_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]  frame_width;
        logic [HEIGHT_BITS-1:0] frame_height;
        logic [MODE_BITS-1:0]   noise_mode;
        logic [TOL_BITS-1:0]    tolerance;
        logic                   use_average;
    } cfg_t;

    // one window column, top row first
    typedef struct packed {
        sample_t top;
        sample_t mid;
        sample_t bot;
    } col_t;

    // beat entering the line store read stage
    typedef struct packed {
        logic    pix;      // pixel: shift window, write back line store
        logic    res;      // beat yields a result
        logic    drain;    // result comes from a drain
        logic    use_win;  // drain value from newest window column
        logic    last;     // final result of the frame
        logic    inner;    // centre is an interior pixel
        sample_t sample;
    } s1_t;

endpackage

// File: hdl/spn_line_store.sv
// Two-row line store: RAM with one read and one write port, read-modify-write and write forwarding.
`timescale 1ns / 1ps

module spn_line_store
    import spn_pkg::*;
#(
    parameter int DEPTH = 2048
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_write,
    input  logic [$clog2(DEPTH)-1:0]   req_addr,
    input  sample_t                    req_sample,
    output logic [2*SAMPLE_BITS-1:0]   rd_data
);

    localparam int AB = $clog2(DEPTH);

    logic [2*SAMPLE_BITS-1:0] mem [DEPTH];
    logic [2*SAMPLE_BITS-1:0] q_reg;
    logic [2*SAMPLE_BITS-1:0] fwd_data_reg;
    logic [2*SAMPLE_BITS-1:0] wr_data;
    logic [AB-1:0]            wr_addr_reg;
    sample_t                  wr_x_reg;
    logic                     wr_pend_reg;
    logic                     fwd_reg;

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;
    // row above moves up, new sample becomes row above
    assign wr_data = {rd_data[SAMPLE_BITS-1:0], wr_x_reg};

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            q_reg <= mem[req_addr];
        end
        if (wr_pend_reg)
        begin
            mem[wr_addr_reg] <= wr_data;
        end
        wr_addr_reg  <= req_addr;
        wr_x_reg     <= req_sample;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= req_valid && req_write;
            fwd_reg     <= wr_pend_reg && req_valid && (req_addr == wr_addr_reg);
        end
    end

endmodule

// File: hdl/spn_window_filter.sv
// 3x3 window registers, neighbour reduction stage and salt/pepper decision stage.
`timescale 1ns / 1ps

module spn_window_filter
    import spn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  s1_t                      s1,
    input  logic [2*SAMPLE_BITS-1:0] rd_data,
    input  cfg_t                     cfg,
    output logic [1:0]               inflight,
    output logic                     push,
    output out_item_t                push_item
);

    localparam int EXT = SAMPLE_BITS + 1;

    col_t                win_reg [3];

    logic                s2_valid_reg;
    logic                s2_drain_reg;
    logic                s2_inner_reg;
    logic                s2_last_reg;
    sample_t             s2_val_reg;

    logic                s3_valid_reg;
    logic                s3_inner_reg;
    logic                s3_last_reg;
    sample_t             s3_centre_reg;
    sample_t             s3_max_reg;
    sample_t             s3_min_reg;
    logic [SUM_BITS-1:0] s3_sum_reg;

    sample_t             nb [NEIGHBOURS];
    sample_t             nb_max;
    sample_t             nb_min;
    logic [SUM_BITS-1:0] nb_sum;
    sample_t             avg;
    logic                salt;
    logic                pepper;

    assign inflight = {1'b0, s2_valid_reg} + {1'b0, s3_valid_reg};

    // stage 1: line store data arrives, window shifts
    always_ff @(posedge clk)
    begin
        if (s1.pix)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= '{top: rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS],
                            mid: rd_data[SAMPLE_BITS-1:0],
                            bot: s1.sample};
        end
        s2_drain_reg <= s1.drain;
        s2_inner_reg <= s1.inner;
        s2_last_reg  <= s1.last;
        s2_val_reg   <= s1.use_win ? win_reg[2].mid : rd_data[SAMPLE_BITS-1:0];
    end

    // stage 2: neighbour max, min and sum
    always_comb
    begin
        nb[0]  = win_reg[0].top;
        nb[1]  = win_reg[0].mid;
        nb[2]  = win_reg[0].bot;
        nb[3]  = win_reg[1].top;
        nb[4]  = win_reg[1].bot;
        nb[5]  = win_reg[2].top;
        nb[6]  = win_reg[2].mid;
        nb[7]  = win_reg[2].bot;
        nb_max = '0;
        nb_min = '1;
        nb_sum = '0;
        for (int k = 0; k < NEIGHBOURS; k++)
        begin
            if (nb[k] > nb_max)
            begin
                nb_max = nb[k];
            end
            if (nb[k] < nb_min)
            begin
                nb_min = nb[k];
            end
            nb_sum = nb_sum + SUM_BITS'(nb[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        s3_inner_reg  <= s2_inner_reg;
        s3_last_reg   <= s2_last_reg;
        s3_centre_reg <= s2_drain_reg ? s2_val_reg : win_reg[1].mid;
        s3_max_reg    <= nb_max;
        s3_min_reg    <= nb_min;
        s3_sum_reg    <= nb_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1.res;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 3: detect and replace, compares widened so nothing wraps
    always_comb
    begin
        salt   = cfg.noise_mode[0] &&
                 ({1'b0, s3_centre_reg} > ({1'b0, s3_max_reg} + EXT'(cfg.tolerance)));
        pepper = cfg.noise_mode[1] &&
                 (({1'b0, s3_centre_reg} + EXT'(cfg.tolerance)) < {1'b0, s3_min_reg});
        avg    = s3_sum_reg[SUM_BITS-1:AVG_SHIFT];
        push_item.out_sample   = s3_centre_reg;
        push_item.was_replaced = 1'b0;
        push_item.noise_kind   = 1'b0;
        push_item.frame_last   = s3_last_reg;
        if (s3_inner_reg && salt)
        begin
            push_item.out_sample   = cfg.use_average ? avg : s3_max_reg;
            push_item.was_replaced = 1'b1;
        end
        else if (s3_inner_reg && pepper)
        begin
            push_item.out_sample   = cfg.use_average ? avg : s3_min_reg;
            push_item.was_replaced = 1'b1;
            push_item.noise_kind   = 1'b1;
        end
    end

    assign push = s3_valid_reg;

endmodule

// File: hdl/spn_out_fifo.sv
// Output queue of result beats, register array with head and tail pointers.
`timescale 1ns / 1ps

module spn_out_fifo
    import spn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  out_item_t               push_item,
    input  logic                    pop,
    output logic                    head_valid,
    output out_item_t               head_item,
    output logic [OUT_CNT_BITS-1:0] count
);

    out_item_t                slot_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0]  wr_ptr_reg;
    logic [OUT_PTR_BITS-1:0]  rd_ptr_reg;
    logic [OUT_CNT_BITS-1:0]  count_reg;
    logic                     do_pop;

    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_BITS'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + OUT_CNT_BITS'(1);
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - OUT_CNT_BITS'(1);
            end
        end
    end

endmodule

// File: hdl/salt_pepper_noise_remover.sv
// Top level: 3x3 salt and pepper impulse noise remover on a raster pixel stream.
//
//  channel  | direction | handshake           | beat
//  ---------+-----------+---------------------+---------------------------------
//  in       | input     | in_valid/in_ready   | in_item_t: opcode, sample
//  out      | output    | out_valid/out_ready | out_item_t: sample, flags, last
//  cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// One input beat per cycle sustained while in_ready is high; a result releasing a beat
// passes s1_reg, the stage 2 and stage 3 registers and the output queue before out_valid.
// The rate is set by the line store RAM: read data arrives in the cycle after accept,
// write-back is registered behind it, forwarded when the next read hits the same column.
// Reset clears control only; line store contents are undefined until written.
// in_ready drops while the 8-entry output queue plus results in flight would be full.
`timescale 1ns / 1ps
`include "salt_pepper_noise_remover_defines.svh"

module salt_pepper_noise_remover
    import spn_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_item_t                 out_data
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int LB = $clog2(MAX_WIDTH + 2);

    cfg_t                     cfg_reg;
    logic [CB-1:0]            col_reg;
    logic [HEIGHT_BITS-1:0]   row_reg;
    logic                     tail_reg;
    logic [LB-1:0]            drain_left_reg;
    logic [LB-1:0]            drain_t_reg;
    s1_t                      s1_reg;
    s1_t                      s1_next;

    logic [WB-1:0]            eff_width;
    logic [HEIGHT_BITS-1:0]   eff_height;
    logic                     in_fire;
    logic                     pix_fire;
    logic                     drn_fire;
    logic                     col_last;
    logic                     row_last;
    logic                     emit;
    logic                     inner;
    logic                     restart;

    logic                     ls_valid;
    logic [CB-1:0]            ls_addr;
    logic [2*SAMPLE_BITS-1:0] ls_data;

    logic [1:0]               wf_inflight;
    logic                     wf_push;
    out_item_t                wf_item;
    logic [OUT_CNT_BITS-1:0]  fifo_count;
    logic [OUT_CNT_BITS-1:0]  occupancy;
    logic                     fifo_pop;

    // effective frame size
    always_comb
    begin
        if (cfg_reg.frame_width == '0)
        begin
            eff_width = WB'(1);
        end
        else if (32'(cfg_reg.frame_width) > 32'(MAX_WIDTH))
        begin
            eff_width = WB'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WB'(cfg_reg.frame_width);
        end
        eff_height = (cfg_reg.frame_height == '0) ? HEIGHT_BITS'(1) : cfg_reg.frame_height;
    end

    assign occupancy = fifo_count + OUT_CNT_BITS'(s1_reg.res) + OUT_CNT_BITS'(wf_inflight);
    assign in_ready  = occupancy < OUT_CNT_BITS'(OUT_DEPTH);
    assign in_fire   = in_valid && in_ready;
    assign pix_fire  = in_fire && (in_data.opcode == OP_PIXEL);
    assign drn_fire  = in_fire && (in_data.opcode == OP_DRAIN) && tail_reg
                       && (drain_left_reg != '0);
    assign restart   = cfg_we && ((cfg_index == CFG_FRAME_WIDTH)
                       || (cfg_index == CFG_FRAME_HEIGHT));

    assign col_last  = WB'(col_reg) == (eff_width - WB'(1));
    assign row_last  = row_reg == (eff_height - HEIGHT_BITS'(1));
    // result lags one row plus one pixel; interior needs two rows and two columns behind
    assign emit      = (row_reg >= HEIGHT_BITS'(2))
                       || ((row_reg == HEIGHT_BITS'(1)) && (col_reg != '0));
    assign inner     = (row_reg >= HEIGHT_BITS'(2)) && (col_reg >= CB'(2));

    assign ls_valid  = pix_fire || (drn_fire && (drain_t_reg != '0));
    assign ls_addr   = pix_fire ? col_reg : CB'(drain_t_reg - LB'(1));

    always_comb
    begin
        s1_next = '0;
        if (pix_fire)
        begin
            s1_next.pix    = 1'b1;
            s1_next.res    = emit;
            s1_next.inner  = inner;
            s1_next.sample = in_data.sample;
        end
        else if (drn_fire)
        begin
            s1_next.res     = 1'b1;
            s1_next.drain   = 1'b1;
            s1_next.use_win = drain_t_reg == '0;
            s1_next.last    = drain_left_reg == LB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{frame_width:  RST_FRAME_WIDTH,
                         frame_height: RST_FRAME_HEIGHT,
                         noise_mode:   RST_NOISE_MODE,
                         tolerance:    RST_TOLERANCE,
                         use_average:  RST_USE_AVERAGE};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[HEIGHT_BITS-1:0];
                CFG_NOISE_MODE:   cfg_reg.noise_mode   <= cfg_data[MODE_BITS-1:0];
                CFG_TOLERANCE:    cfg_reg.tolerance    <= cfg_data[TOL_BITS-1:0];
                CFG_USE_AVERAGE:  cfg_reg.use_average  <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            tail_reg       <= 1'b0;
            drain_left_reg <= '0;
            drain_t_reg    <= '0;
            s1_reg         <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            if (restart)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                tail_reg <= 1'b0;
            end
            else if (pix_fire)
            begin
                tail_reg <= 1'b0;
                if (col_last)
                begin
                    col_reg <= '0;
                    if (row_last)
                    begin
                        row_reg  <= '0;
                        tail_reg <= 1'b1;
                        // single-row frame: every pixel drains from the line store
                        if (eff_height == HEIGHT_BITS'(1))
                        begin
                            drain_left_reg <= LB'(eff_width);
                            drain_t_reg    <= LB'(1);
                        end
                        else
                        begin
                            drain_left_reg <= LB'(eff_width) + LB'(1);
                            drain_t_reg    <= '0;
                        end
                    end
                    else
                    begin
                        row_reg <= row_reg + HEIGHT_BITS'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + CB'(1);
                end
            end
            else if (drn_fire)
            begin
                drain_left_reg <= drain_left_reg - LB'(1);
                drain_t_reg    <= drain_t_reg + LB'(1);
            end
        end
    end

    spn_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (ls_valid),
        .req_write  (pix_fire),
        .req_addr   (ls_addr),
        .req_sample (in_data.sample),
        .rd_data    (ls_data)
    );

    spn_window_filter u_window_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1_reg),
        .rd_data   (ls_data),
        .cfg       (cfg_reg),
        .inflight  (wf_inflight),
        .push      (wf_push),
        .push_item (wf_item)
    );

    assign fifo_pop = out_valid && out_ready;

    spn_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (wf_push),
        .push_item  (wf_item),
        .pop        (fifo_pop),
        .head_valid (out_valid),
        .head_item  (out_data),
        .count      (fifo_count)
    );

    `SPN_ASSERT_NOW(a_queue_no_overflow, wf_push, (fifo_count < OUT_CNT_BITS'(OUT_DEPTH)) || fifo_pop, "output queue overflow")
    `SPN_ASSERT_NOW(a_tail_at_origin, tail_reg, (col_reg == '0) && (row_reg == '0), "tail pending away from frame origin")
    `SPN_ASSERT_NEXT(a_drain_yields, drn_fire, s1_reg.res && s1_reg.drain && !s1_reg.pix, "pending drain beat lost its result")

endmodule
